// ===== rtl/ddodom_pkg.sv =====
// shared types and constants for the differential drive odometry unit
`default_nettype none

package ddodom_pkg;

	// register index decoded from the config address
	localparam logic [0:0] REG_DIST = 1'b0;
	localparam logic [0:0] REG_TURN = 1'b1;

	// cordic operand widths and start value (gain compensated 1.0 in Q.24)
	localparam int CW = 26;
	localparam int ZW = 33;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 26'sd10188014;

	// arctangent of 2^-i in turns / 2^32
	localparam int ATAN_N  = 24;
	localparam int ATAN_IW = 5;
	localparam logic [31:0] ATAN_TURN32 [0:ATAN_N-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIST,
		OP_TURN,
		OP_WRAP,
		OP_INIT,
		OP_ROT,
		OP_FLIP,
		OP_MXH,
		OP_MXL,
		OP_MYH,
		OP_MYL,
		OP_ACC,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic rot_last;
	} dp_sts_t;

	typedef struct packed {
		logic [23:0] tick_travel;
		logic [23:0] turn_per_tick;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ===== rtl/differential_drive_odometry_unit.sv =====
// top level of the differential drive odometry unit
//
//   channel   handshake              word
//   input     in_valid / in_ready    left_ticks, right_ticks, sequence_req
//   output    out_valid / out_ready  x_position, y_position, heading, sequence_out
//   config    apb psel/penable       travel per tick @0x0, turn_per_tick @0x4
//
// a new input word is taken only once the last one has passed through every state,
// paced by the cordic iterations and the shared multiplier used six times
// the next input word is taken while a finished result still waits at the output
// reset clears pose, heading and both registers; no clearing pass is needed
// an output stall holds the block in its last state until the result slot frees
`default_nettype none

module differential_drive_odometry_unit #(
	parameter int CORDIC_STEPS = 18,
	parameter int TICK_BITS    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// input words
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [TICK_BITS-1:0] left_ticks,
	input  wire logic signed [TICK_BITS-1:0] right_ticks,
	input  wire logic        [31:0]          sequence_req,
	// output words
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed      [47:0]          x_position,
	output logic signed      [47:0]          y_position,
	output logic signed      [24:0]          heading,
	output logic             [31:0]          sequence_out
);
	import ddodom_pkg::*;

	cfg_regs_t cfg;
	dp_cmd_t   cmd;
	dp_sts_t   sts;

	// register file
	ddodom_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// controller
	ddodom_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	ddodom_dp #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.TICK_BITS    (TICK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.left_ticks   (left_ticks),
		.right_ticks  (right_ticks),
		.sequence_req (sequence_req),
		.x_position   (x_position),
		.y_position   (y_position),
		.heading      (heading),
		.sequence_out (sequence_out)
	);

endmodule

`default_nettype wire

// ===== rtl/ddodom_cfg.sv =====
// apb register file holding distance and turn per tick
`default_nettype none

module ddodom_cfg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output ddodom_pkg::cfg_regs_t      cfg
);
	import ddodom_pkg::*;

	logic [23:0] dist_q;
	logic [23:0] turn_q;
	logic [0:0]  idx;
	logic        wr_en;

	assign idx    = paddr[2:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			turn_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_DIST: dist_q <= pwdata[23:0];
				REG_TURN: turn_q <= pwdata[23:0];
				default:  dist_q <= dist_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_DIST: prdata = {8'b0, dist_q};
			REG_TURN: prdata = {8'b0, turn_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg.tick_travel   = dist_q;
	assign cfg.turn_per_tick = turn_q;

endmodule

`default_nettype wire

// ===== rtl/ddodom_ctrl.sv =====
// sequencing state machine for the odometry datapath
`default_nettype none

module ddodom_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire ddodom_pkg::dp_sts_t sts,
	output ddodom_pkg::dp_cmd_t      cmd
);
	import ddodom_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DIST = 13'b0000000000010,
		S_TURN = 13'b0000000000100,
		S_WRAP = 13'b0000000001000,
		S_INIT = 13'b0000000010000,
		S_ROT  = 13'b0000000100000,
		S_FLIP = 13'b0000001000000,
		S_MXH  = 13'b0000010000000,
		S_MXL  = 13'b0000100000000,
		S_MYH  = 13'b0001000000000,
		S_MYL  = 13'b0010000000000,
		S_ACC  = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// next state and datapath command
	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = S_DIST;
				end
			end
			S_DIST: begin
				cmd.op    = OP_DIST;
				state_nxt = S_TURN;
			end
			S_TURN: begin
				cmd.op    = OP_TURN;
				state_nxt = S_WRAP;
			end
			S_WRAP: begin
				cmd.op    = OP_WRAP;
				state_nxt = S_INIT;
			end
			S_INIT: begin
				cmd.op    = OP_INIT;
				state_nxt = S_ROT;
			end
			S_ROT: begin
				cmd.op = OP_ROT;
				if (sts.rot_last) begin
					state_nxt = S_FLIP;
				end
			end
			S_FLIP: begin
				cmd.op    = OP_FLIP;
				state_nxt = S_MXH;
			end
			S_MXH: begin
				cmd.op    = OP_MXH;
				state_nxt = S_MXL;
			end
			S_MXL: begin
				cmd.op    = OP_MXL;
				state_nxt = S_MYH;
			end
			S_MYH: begin
				cmd.op    = OP_MYH;
				state_nxt = S_MYL;
			end
			S_MYL: begin
				cmd.op    = OP_MYL;
				state_nxt = S_ACC;
			end
			S_ACC: begin
				cmd.op    = OP_ACC;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					cmd.op    = OP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ddodom_dp.sv =====
// odometry datapath: shared multiplier, heading wrap, iterative cordic, pose
`default_nettype none

module ddodom_dp #(
	parameter int CORDIC_STEPS = 18,
	parameter int TICK_BITS    = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ddodom_pkg::dp_cmd_t           cmd,
	output ddodom_pkg::dp_sts_t                sts,
	input  wire ddodom_pkg::cfg_regs_t         cfg,
	input  wire logic signed [TICK_BITS-1:0]   left_ticks,
	input  wire logic signed [TICK_BITS-1:0]   right_ticks,
	input  wire logic        [31:0]            sequence_req,
	output logic signed      [47:0]            x_position,
	output logic signed      [47:0]            y_position,
	output logic signed      [24:0]            heading,
	output logic             [31:0]            sequence_out
);
	import ddodom_pkg::*;

	localparam int TB  = TICK_BITS;
	localparam int AW  = (TB + 1 > 25) ? TB + 1 : 25;
	localparam int BW  = CW;
	localparam int PW  = AW + BW;
	localparam int DW  = TB + 24;
	localparam int YSW = ((TB + 17 > 25) ? TB + 17 : 25) + 1;
	localparam int SW  = $clog2(CORDIC_STEPS);

	// item registers
	logic signed [TB-1:0]  l_q;
	logic signed [TB-1:0]  r_q;
	logic        [31:0]    seq_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [DW-1:0]  dist_q;
	logic signed [24:0]    yaw_q;
	logic signed [CW-1:0]  cx_q;
	logic signed [CW-1:0]  cy_q;
	logic signed [ZW-1:0]  cz_q;
	logic                  flip_q;
	logic        [SW-1:0]  step_q;
	logic        [47:0]    pos_x_q;
	logic        [47:0]    pos_y_q;

	// combinational terms
	logic signed [TB:0]      sum_w;
	logic signed [TB:0]      diff_w;
	logic signed [TB-1:0]    dist_hi;
	logic signed [AW-1:0]    a_op;
	logic signed [BW-1:0]    b_op;
	logic signed [PW-1:0]    prod_w;
	logic signed [PW+47:0]   prod_wide;
	logic        [47:0]      hi_term;
	logic        [47:0]      lo_term;
	logic signed [YSW-1:0]   dyaw_w;
	logic signed [YSW-1:0]   ysum_w;
	logic        [24:0]      yaw_nxt;
	logic        [23:0]      ang;
	logic                    fold;
	logic        [23:0]      ang_f;
	logic signed [CW-1:0]    dx_w;
	logic signed [CW-1:0]    dy_w;
	logic signed [ZW-1:0]    atan_w;
	logic [ATAN_IW-1:0]      step_idx;

	assign sum_w   = {l_q[TB-1], l_q} + {r_q[TB-1], r_q};
	assign diff_w  = {r_q[TB-1], r_q} - {l_q[TB-1], l_q};
	assign dist_hi = dist_q[DW-1:24];

	// shared multiplier operand select
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.op)
			OP_DIST: begin
				a_op = AW'(sum_w);
				b_op = BW'({1'b0, cfg.tick_travel});
			end
			OP_TURN: begin
				a_op = AW'(diff_w);
				b_op = BW'({1'b0, cfg.turn_per_tick});
			end
			OP_MXH: begin
				a_op = AW'(dist_hi);
				b_op = cx_q;
			end
			OP_MXL: begin
				a_op = AW'(signed'({1'b0, dist_q[23:0]}));
				b_op = cx_q;
			end
			OP_MYH: begin
				a_op = AW'(dist_hi);
				b_op = cy_q;
			end
			OP_MYL: begin
				a_op = AW'(signed'({1'b0, dist_q[23:0]}));
				b_op = cy_q;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod_w = PW'(a_op * b_op);

	// position terms: whole part times k, fraction part times k over 2^24
	assign prod_wide = (PW + 48)'(prod_q);
	assign hi_term   = prod_wide[47:0];
	assign lo_term   = prod_wide[71:24];

	// heading update with sign-keeping wrap at one turn
	assign dyaw_w  = YSW'(prod_q >>> 8);
	assign ysum_w  = YSW'(yaw_q) + dyaw_w;
	assign yaw_nxt = {ysum_w[YSW-1] && (ysum_w[23:0] != 24'd0), ysum_w[23:0]};

	// fold angle into a quarter turn around zero
	assign ang   = yaw_q[23:0];
	assign fold  = ang[23] ^ ang[22];
	assign ang_f = {ang[23] ^ fold, ang[22:0]};

	// cordic micro-rotation terms
	assign step_idx = ATAN_IW'(step_q);
	assign dx_w     = cy_q >>> step_q;
	assign dy_w     = cx_q >>> step_q;
	assign atan_w   = {1'b0, ATAN_TURN32[step_idx]};

	assign sts.rot_last = (step_q == SW'(CORDIC_STEPS - 1));

	// pose state and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			yaw_q   <= '0;
			flip_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			case (cmd.op)
				OP_WRAP: yaw_q <= yaw_nxt;
				OP_INIT: begin
					flip_q <= fold;
					step_q <= '0;
				end
				OP_ROT:  step_q  <= step_q + 1'b1;
				OP_MXL:  pos_x_q <= pos_x_q + hi_term;
				OP_MYH:  pos_x_q <= pos_x_q + lo_term;
				OP_MYL:  pos_y_q <= pos_y_q + hi_term;
				OP_ACC:  pos_y_q <= pos_y_q + lo_term;
				default: step_q  <= step_q;
			endcase
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		prod_q <= prod_w;
		case (cmd.op)
			OP_LOAD: begin
				l_q   <= left_ticks;
				r_q   <= right_ticks;
				seq_q <= sequence_req;
			end
			OP_TURN: dist_q <= DW'(prod_q >>> 1);
			OP_INIT: begin
				cx_q <= CORDIC_GAIN;
				cy_q <= '0;
				cz_q <= {ang_f[23], ang_f, 8'b0};
			end
			OP_ROT: begin
				if (!cz_q[ZW-1]) begin
					cx_q <= cx_q - dx_w;
					cy_q <= cy_q + dy_w;
					cz_q <= cz_q - atan_w;
				end else begin
					cx_q <= cx_q + dx_w;
					cy_q <= cy_q - dy_w;
					cz_q <= cz_q + atan_w;
				end
			end
			OP_FLIP: begin
				if (flip_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			OP_OUT: begin
				x_position   <= pos_x_q;
				y_position   <= pos_y_q;
				heading      <= yaw_q;
				sequence_out <= seq_q;
			end
			default: seq_q <= seq_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ddodom_chk.sv =====
// port-level checker for the odometry unit and its bind
`default_nettype none

module ddodom_chk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pready,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [47:0] x_position,
	input  wire logic signed [24:0] heading,
	input  wire logic        [31:0] sequence_out
);
	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_position)
			&& $stable(sequence_out))
		else $error("output word changed while stalled");

	// no result without an item behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word without an accepted input");

	// at most one item in work plus one waiting result
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many words in flight");

	// an accepted word closes the input at once
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input reopened right after accept");

	// heading never shows a full negative turn and pready is high while a result is valid
	a_heading_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading != 25'h1000000 && pready)
		else $error("heading outside one turn or bus not ready");

endmodule

bind differential_drive_odometry_unit ddodom_chk u_ddodom_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.x_position   (x_position),
	.heading      (heading),
	.sequence_out (sequence_out)
);

`default_nettype wire
